@@ rtl/irn_pkg.sv @@
`default_nettype none

package irn_pkg;

    localparam int unsigned ValueWidth = 12;
    localparam int unsigned IndexWidth = 4;
    localparam int unsigned CharWidth  = 8;

    localparam logic [ValueWidth-1:0] MaxValid = 12'd3999;

    localparam logic [CharWidth-1:0] CharI = 8'h49;
    localparam logic [CharWidth-1:0] CharV = 8'h56;
    localparam logic [CharWidth-1:0] CharX = 8'h58;
    localparam logic [CharWidth-1:0] CharL = 8'h4C;
    localparam logic [CharWidth-1:0] CharC = 8'h43;
    localparam logic [CharWidth-1:0] CharD = 8'h44;
    localparam logic [CharWidth-1:0] CharM = 8'h4D;
    localparam logic [CharWidth-1:0] CharNone = 8'h00;

    // Result of one compare-and-subtract against the current table entry.
    typedef struct packed {
        logic                  fits;
        logic [ValueWidth-1:0] diff;
        logic [CharWidth-1:0]  first_char;
        logic [CharWidth-1:0]  second_char;
        logic                  pair;
    } step_t;

    function automatic logic [ValueWidth-1:0] roman_value(input logic [IndexWidth-1:0] idx);
        logic [ValueWidth-1:0] v;
        unique case (idx)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic logic [CharWidth-1:0] roman_first(input logic [IndexWidth-1:0] idx);
        logic [CharWidth-1:0] c;
        unique case (idx)
            4'd0:    c = CharM;
            4'd1:    c = CharC;
            4'd2:    c = CharD;
            4'd3:    c = CharC;
            4'd4:    c = CharC;
            4'd5:    c = CharX;
            4'd6:    c = CharL;
            4'd7:    c = CharX;
            4'd8:    c = CharX;
            4'd9:    c = CharI;
            4'd10:   c = CharV;
            default: c = CharI;
        endcase
        return c;
    endfunction

    function automatic logic [CharWidth-1:0] roman_second(input logic [IndexWidth-1:0] idx);
        logic [CharWidth-1:0] c;
        unique case (idx)
            4'd1:    c = CharM;
            4'd3:    c = CharD;
            4'd5:    c = CharC;
            4'd7:    c = CharL;
            4'd9:    c = CharX;
            4'd11:   c = CharV;
            default: c = CharNone;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/irn_step_unit.sv @@
`default_nettype none

// Shared compare-and-subtract unit: checks the remaining value against one
// table entry and looks up the symbol letters for that entry.
module irn_step_unit (
    input  wire logic [irn_pkg::ValueWidth-1:0] remaining,
    input  wire logic [irn_pkg::IndexWidth-1:0] idx,
    output irn_pkg::step_t                      step
);

    logic [irn_pkg::ValueWidth-1:0] table_value;

    always_comb
    begin
        table_value      = irn_pkg::roman_value(idx);
        step.fits        = (remaining >= table_value);
        step.diff        = remaining - table_value;
        step.first_char  = irn_pkg::roman_first(idx);
        step.second_char = irn_pkg::roman_second(idx);
        step.pair        = (step.second_char != irn_pkg::CharNone);
    end

endmodule

`default_nettype wire

@@ rtl/integer_to_roman_numeral.sv @@
`default_nettype none

// Integer to Roman numeral converter. Each input transaction carries a 12-bit
// number; the block answers with one output transaction per ASCII letter of
// its Roman numeral (I V X L C D M), with last set on the final letter and
// error clear. A number of 0 or above 3999 instead gives exactly one output
// transaction with character 0, last 1 and error 1. Conversion is greedy over
// the 13-entry table 1000, 900, 500, ... 4, 1 using a single compare-and-
// subtract unit under a small sequencer: each cycle it either emits one
// letter, steps to the next table entry, or waits while the letter it owes
// finds the output register full. The longest numeral, for 3888, has 15
// letters. Results sit in an output register, so a letter may wait for the
// consumer while the sequencer keeps advancing table entries. Only one number
// is in flight at a time: in_ready is high when the sequencer is idle and the
// output register is free or being emptied.
module integer_to_roman_numeral (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [irn_pkg::ValueWidth-1:0] number,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [irn_pkg::CharWidth-1:0]       character,
    output logic                                last,
    output logic                                error
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                         state_reg, state_next;
    logic [irn_pkg::ValueWidth-1:0] rem_reg, rem_next;
    logic [irn_pkg::IndexWidth-1:0] idx_reg, idx_next;
    logic                           pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;
    logic [irn_pkg::CharWidth-1:0]  char_reg, char_next;
    logic                           last_reg, last_next;
    logic                           err_reg, err_next;

    logic           out_free;
    logic           in_take;
    logic           bad_number;
    irn_pkg::step_t step;

    irn_step_unit u_step (
        .remaining (rem_reg),
        .idx       (idx_reg),
        .step      (step)
    );

    // The output register can take a new letter when empty or being read.
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) && out_free;
    assign in_take    = in_valid && in_ready;
    assign bad_number = (number == '0) || (number > irn_pkg::MaxValid);

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        err_next       = err_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (bad_number)
                    begin
                        // Out-of-range numbers get a single flagged result.
                        out_valid_next = 1'b1;
                        char_next      = irn_pkg::CharNone;
                        last_next      = 1'b1;
                        err_next       = 1'b1;
                    end
                    else
                    begin
                        rem_next   = number;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (pend_reg)
                begin
                    // Second letter of a subtractive pair such as CM or IV.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        char_next      = step.second_char;
                        last_next      = (rem_reg == '0);
                        err_next       = 1'b0;
                        pend_next      = 1'b0;
                        if (rem_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (step.fits)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        char_next      = step.first_char;
                        err_next       = 1'b0;
                        rem_next       = step.diff;
                        if (step.pair)
                        begin
                            pend_next = 1'b1;
                            last_next = 1'b0;
                        end
                        else
                        begin
                            last_next = (step.diff == '0);
                            if (step.diff == '0)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
                else
                begin
                    // The remaining value is below this entry: move down.
                    idx_next = idx_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
            err_reg       <= err_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign error     = err_reg;

`ifndef SYNTHESIS
    // An error result is always a single, final, blank character.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && (character == irn_pkg::CharNone))
        else $error("error result is not a lone final blank character");

    // A normal result is always one of the seven numeral letters.
    a_letter_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |->
            (character == irn_pkg::CharI) || (character == irn_pkg::CharV) ||
            (character == irn_pkg::CharX) || (character == irn_pkg::CharL) ||
            (character == irn_pkg::CharC) || (character == irn_pkg::CharD) ||
            (character == irn_pkg::CharM))
        else $error("normal result carries a non-numeral character");

    // A zero input yields the error result on the very next cycle.
    a_zero_error: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (number == '0) |=> out_valid && error)
        else $error("zero input did not produce an error result");

    // While converting with no second letter owed, some value must remain.
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && !pend_reg |-> (rem_reg != '0))
        else $error("sequencer running with nothing left to convert");
`endif

endmodule

`default_nettype wire

@@ sim/roman_numeral_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the converter, spells each accepted number
// independently and compares every output transaction with the oldest
// expected letter.
module roman_numeral_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [irn_pkg::ValueWidth-1:0] number,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [irn_pkg::CharWidth-1:0]  character,
    input  wire logic                           last,
    input  wire logic                           error,
    output int                                  mismatches,
    output int                                  letters_owed
);

    typedef struct packed {
        logic [irn_pkg::CharWidth-1:0] character;
        logic                          last;
        logic                          error;
    } letter_t;

    letter_t                       owed_letters[$];
    logic [irn_pkg::CharWidth-1:0] spelling[$];
    letter_t                       want;
    int                            fail_total = 0;

    // Spells one decimal digit with the letters for one, five and ten of its place.
    task automatic spell_digit(input int digit, input logic [irn_pkg::CharWidth-1:0] one,
                               input logic [irn_pkg::CharWidth-1:0] five,
                               input logic [irn_pkg::CharWidth-1:0] ten);
        int k;
        if (digit == 9)
        begin
            spelling.push_back(one);
            spelling.push_back(ten);
        end
        else if (digit == 4)
        begin
            spelling.push_back(one);
            spelling.push_back(five);
        end
        else
        begin
            if (digit >= 5)
                spelling.push_back(five);
            for (k = 0; k < digit % 5; k++)
                spelling.push_back(one);
        end
    endtask

    task automatic expect_numeral(input logic [irn_pkg::ValueWidth-1:0] value);
        letter_t entry;
        int      v;
        int      k;
        v = int'(value);
        if (v == 0 || v > int'(irn_pkg::MaxValid))
        begin
            entry.character = irn_pkg::CharNone;
            entry.last      = 1'b1;
            entry.error     = 1'b1;
            owed_letters.push_back(entry);
        end
        else
        begin
            spelling.delete();
            spell_digit(v / 1000, irn_pkg::CharM, irn_pkg::CharNone, irn_pkg::CharNone);
            spell_digit((v / 100) % 10, irn_pkg::CharC, irn_pkg::CharD, irn_pkg::CharM);
            spell_digit((v / 10) % 10, irn_pkg::CharX, irn_pkg::CharL, irn_pkg::CharC);
            spell_digit(v % 10, irn_pkg::CharI, irn_pkg::CharV, irn_pkg::CharX);
            for (k = 0; k < spelling.size(); k++)
            begin
                entry.character = spelling[k];
                entry.last      = (k == spelling.size() - 1);
                entry.error     = 1'b0;
                owed_letters.push_back(entry);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expect_numeral(number);
            if (out_valid && out_ready)
            begin
                if (owed_letters.size() == 0)
                begin
                    $display("%0t: expected no output transaction, got character %h last %b error %b",
                             $time, character, last, error);
                    fail_total++;
                end
                else
                begin
                    want = owed_letters.pop_front();
                    if (character !== want.character)
                    begin
                        $display("%0t: character expected %h got %h",
                                 $time, want.character, character);
                        fail_total++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %b got %b", $time, want.last, last);
                        fail_total++;
                    end
                    if (error !== want.error)
                    begin
                        $display("%0t: error expected %b got %b", $time, want.error, error);
                        fail_total++;
                    end
                end
            end
        end
        mismatches   <= fail_total;
        letters_owed <= owed_letters.size();
    end

endmodule

@@ sim/integer_to_roman_numeral_test.sv @@
`timescale 1ns / 1ps

module integer_to_roman_numeral_test;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [irn_pkg::ValueWidth-1:0] number = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [irn_pkg::CharWidth-1:0]  character;
    logic                           last;
    logic                           error;

    int mismatches;
    int letters_owed;

    // When calm is set, neither side inserts idle cycles any more. When
    // hold_output is set, the consumer refuses output for a long stretch.
    logic calm = 1'b0;
    logic hold_output = 1'b0;

    integer_to_roman_numeral dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last),
        .error     (error)
    );

    roman_numeral_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .number       (number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .character    (character),
        .last         (last),
        .error        (error),
        .mismatches   (mismatches),
        .letters_owed (letters_owed)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // This bound lies well above the slowest legal run, so it only
    // trips when the block hangs or drops a transaction.
    initial
    begin
        #5_000_000;
        $display("integer_to_roman_numeral test failed");
        $finish;
    end

    // Mostly in-range numbers, with a bias toward short numerals so that the
    // per-number overhead gets exercised, plus zero and the out-of-range band.
    function automatic logic [irn_pkg::ValueWidth-1:0] pick_number();
        int roll;
        logic [irn_pkg::ValueWidth-1:0] value;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            value = '0;
        else if (roll < 14)
            value = irn_pkg::ValueWidth'($urandom_range(4000, 4095));
        else if (roll < 40)
            value = irn_pkg::ValueWidth'($urandom_range(1, 99));
        else
            value = irn_pkg::ValueWidth'($urandom_range(1, 3999));
        return value;
    endfunction

    // Offers one number and returns at the edge where it is accepted. An
    // optional idle burst comes first, with noise on the number bus.
    task automatic offer_number(input logic [irn_pkg::ValueWidth-1:0] value);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            number   <= irn_pkg::ValueWidth'($urandom_range(0, 4095));
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stops offering and waits until every expected letter has come out.
    task automatic wait_for_letters();
        in_valid <= 1'b0;
        @(posedge clk);
        while (letters_owed != 0)
            @(posedge clk);
    endtask

    // Consumer side. Most cycles it is ready; now and then it drops ready for
    // a random burst, and once it holds off for a long stretch
    // so that the converter backs up and stalls its input.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_output <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Producer side and verdict.
    initial
    begin
        logic [irn_pkg::ValueWidth-1:0] corner_numbers[$];
        int k;

        corner_numbers = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888,
                           12'd4, 12'd9, 12'd14, 12'd40, 12'd90, 12'd400, 12'd900,
                           12'd444, 12'd999, 12'd1994, 12'd2048, 12'd3, 12'd5,
                           12'd10, 12'd50, 12'd100, 12'd500, 12'd1000, 12'd49};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions: range edges, every table entry on its own,
        // the longest numeral, and the error band.
        for (k = 0; k < corner_numbers.size(); k++)
            offer_number(corner_numbers[k]);

        for (k = 0; k < 150; k++)
            offer_number(pick_number());

        // Long consumer hold-off while the producer keeps offering.
        hold_output <= 1'b1;
        for (k = 0; k < 20; k++)
            offer_number(pick_number());

        // Let the converter empty out completely before going on.
        wait_for_letters();

        for (k = 0; k < 100; k++)
            offer_number(pick_number());

        // Final stretch at full rate on both sides.
        calm <= 1'b1;
        for (k = 0; k < 80; k++)
            offer_number(pick_number());

        wait_for_letters();
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("integer_to_roman_numeral test passed");
        else
            $display("integer_to_roman_numeral test failed");
        $finish;
    end

endmodule
